/* rtl/core/ppos_pkg.sv */
// ----------------------------------------------------------------------------
// ppos_pkg: shared constants for the point onto segment projection
// Field widths, internal datapath widths, pipeline latencies and region codes.
// ----------------------------------------------------------------------------
package ppos_pkg;

  // Coordinate and difference widths (signed Q16.8 inputs).
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int FOOT_W  = COORD_W + 2;

  // Products of two magnitudes and their sums.
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int LEN_W   = PROD_W;
  localparam int DOT_W   = LEN_W + 2;
  localparam int HALF_W  = DIFF_W;

  // Rounded quotient: numerator 2n + d over denominator 2d.
  localparam int NUM_W   = 76;
  localparam int DEN_W   = LEN_W + 1;
  localparam int QUOT_W  = 27;
  localparam int DIV_LAT = QUOT_W + 1;

  // Distances and the square root unit.
  localparam int DIST_W   = 26;
  localparam int SQ_W     = 2 * DIST_W + 1;
  localparam int ROOT_W   = 27;
  localparam int SQRT_LAT = ROOT_W + 2;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Latency from an accepted beat to its result strobe.
  localparam int FRONT_LAT = 8;
  localparam int BACK_LAT  = 3;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + BACK_LAT + SQRT_LAT;

  // Region codes.
  localparam logic [1:0] REG_INSIDE = 2'd0;
  localparam logic [1:0] REG_BEFORE = 2'd1;
  localparam logic [1:0] REG_PAST   = 2'd2;
  localparam logic [1:0] REG_ZERO   = 2'd3;

endpackage

/* rtl/core/project_point_onto_segment.sv */
// ----------------------------------------------------------------------------
// project_point_onto_segment: clamped projection of a point onto a segment
// Foot point, distance beyond the nearer end and distance to the foot.
// ----------------------------------------------------------------------------
//  channel  | ports                             | handshake
//  ---------+-----------------------------------+---------------------------
//  input    | in_point_*, in_start_*, in_stop_* | start high, busy low
//  result   | out_foot_*, out_*_distance,       | out_strobe high one cycle
//           | out_region                        |
//
// A beat is accepted every cycle; busy stays low. Each result passes through 8
// front stages, 28 divider stages, 3 back stages, then 29 square root stages.
// The divider and the square root each resolve one bit per stage.
// Reset clears only the valid bits, so no strobe follows reset until new beats.
// The receiver cannot stall; the pipeline never holds.
module project_point_onto_segment (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ppos_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [ppos_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [ppos_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [ppos_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [ppos_pkg::COORD_W-1:0]  in_stop_x,
  input  logic signed [ppos_pkg::COORD_W-1:0]  in_stop_y,
  output logic                                 out_strobe,
  output logic signed [ppos_pkg::COORD_W-1:0]  out_foot_x,
  output logic signed [ppos_pkg::COORD_W-1:0]  out_foot_y,
  output logic [ppos_pkg::DIST_W-1:0]          out_outside_distance,
  output logic [ppos_pkg::DIST_W-1:0]          out_segment_distance,
  output logic [1:0]                           out_region
);

  localparam int CO = ppos_pkg::COORD_W;
  localparam int DF = ppos_pkg::DIFF_W;
  localparam int FW = ppos_pkg::FOOT_W;
  localparam int PW = ppos_pkg::PROD_W;
  localparam int LW = ppos_pkg::LEN_W;
  localparam int TW = ppos_pkg::DOT_W;
  localparam int HW = ppos_pkg::HALF_W;
  localparam int NW = ppos_pkg::NUM_W;
  localparam int EW = ppos_pkg::DEN_W;
  localparam int QW = ppos_pkg::QUOT_W;
  localparam int SW = ppos_pkg::DIST_W;
  localparam int VW = ppos_pkg::SQ_W;
  localparam int DL = ppos_pkg::DIV_LAT;
  localparam int RL = ppos_pkg::SQRT_LAT;

  typedef struct packed {
    logic signed [CO-1:0] x;
    logic signed [CO-1:0] y;
    logic signed [CO-1:0] ax;
    logic signed [CO-1:0] ay;
    logic signed [CO-1:0] bx;
    logic signed [CO-1:0] by;
  } crd_t;

  typedef struct packed {
    logic [DF-1:0] mpx;
    logic [DF-1:0] mpy;
    logic [DF-1:0] mqx;
    logic [DF-1:0] mqy;
    logic [DF-1:0] mdx;
    logic [DF-1:0] mdy;
    logic          dxn;
    logic          dyn;
  } mag_t;

  typedef struct packed {
    crd_t       crd;
    mag_t       mg;
    logic [1:0] region;
  } dly_t;

  typedef struct packed {
    logic signed [CO-1:0] fx;
    logic signed [CO-1:0] fy;
    logic [1:0]           region;
  } bdl_t;

  function automatic logic [DF-1:0] mag_f(logic signed [DF-1:0] v);
    return v[DF-1] ? DF'(-v) : DF'(v);
  endfunction

  function automatic logic [FW-1:0] mag26_f(logic signed [FW-1:0] v);
    return v[FW-1] ? FW'(-v) : FW'(v);
  endfunction

  // Every cycle takes a beat.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- front
  logic                 vld_r [1:ppos_pkg::FRONT_LAT];
  crd_t                 crd_r [1:ppos_pkg::FRONT_LAT];
  mag_t                 mag_r [2:ppos_pkg::FRONT_LAT];

  logic signed [DF-1:0] px1_r, py1_r, dx1_r, dy1_r, qx1_r, qy1_r;
  logic                 negx2_r, negy2_r;
  logic [PW-1:0]        tx3_r, ty3_r, lx3_r, ly3_r;
  logic                 negx3_r, negy3_r;
  logic [LW-1:0]        len4_r;
  logic signed [TW-1:0] dot4_r;
  logic [LW-1:0]        len5_r, dmag5_r;
  logic                 dneg5_r, zero5_r;
  logic [LW-1:0]        len6_r, nb6_r;
  logic [1:0]           reg6_r;
  logic [PW-1:0]        hx7_r, lx7_r, hy7_r, ly7_r;
  logic [LW-1:0]        len7_r;
  logic [1:0]           reg7_r;
  logic [NW-1:0]        numx8_r, numy8_r;
  logic [EW-1:0]        den8_r;
  logic [1:0]           reg8_r;

  logic signed [TW-1:0] dot4_nxt;
  logic signed [TW-1:0] e6;
  logic [1:0]           reg6_nxt;

  // Signed dot product from the two magnitude products.
  always_comb begin : p_dot
    logic signed [TW-1:0] tx, ty;
    tx = $signed({2'b00, tx3_r});
    ty = $signed({2'b00, ty3_r});
    dot4_nxt = (negx3_r ? -tx : tx) + (negy3_r ? -ty : ty);
  end

  // Region from the dot product against the squared length.
  always_comb begin
    e6 = $signed({2'b00, dmag5_r}) - $signed({2'b00, len5_r});
    if (zero5_r) begin
      reg6_nxt = ppos_pkg::REG_ZERO;
    end else if (dneg5_r) begin
      reg6_nxt = ppos_pkg::REG_BEFORE;
    end else if (!e6[TW-1] && e6 != '0) begin
      reg6_nxt = ppos_pkg::REG_PAST;
    end else begin
      reg6_nxt = ppos_pkg::REG_INSIDE;
    end
  end

  // Front valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ppos_pkg::FRONT_LAT; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[1] <= start && !busy;
      for (int k = 2; k <= ppos_pkg::FRONT_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Front datapath: differences, magnitudes, products, region, numerators.
  always_ff @(posedge clk) begin
    crd_r[1].x  <= in_point_x;
    crd_r[1].y  <= in_point_y;
    crd_r[1].ax <= in_start_x;
    crd_r[1].ay <= in_start_y;
    crd_r[1].bx <= in_stop_x;
    crd_r[1].by <= in_stop_y;
    px1_r <= DF'(in_point_x) - DF'(in_start_x);
    py1_r <= DF'(in_point_y) - DF'(in_start_y);
    dx1_r <= DF'(in_stop_x) - DF'(in_start_x);
    dy1_r <= DF'(in_stop_y) - DF'(in_start_y);
    qx1_r <= DF'(in_point_x) - DF'(in_stop_x);
    qy1_r <= DF'(in_point_y) - DF'(in_stop_y);
    for (int k = 2; k <= ppos_pkg::FRONT_LAT; k++) crd_r[k] <= crd_r[k-1];

    mag_r[2].mpx <= mag_f(px1_r);
    mag_r[2].mpy <= mag_f(py1_r);
    mag_r[2].mqx <= mag_f(qx1_r);
    mag_r[2].mqy <= mag_f(qy1_r);
    mag_r[2].mdx <= mag_f(dx1_r);
    mag_r[2].mdy <= mag_f(dy1_r);
    mag_r[2].dxn <= dx1_r[DF-1];
    mag_r[2].dyn <= dy1_r[DF-1];
    negx2_r <= px1_r[DF-1] != dx1_r[DF-1];
    negy2_r <= py1_r[DF-1] != dy1_r[DF-1];
    for (int k = 3; k <= ppos_pkg::FRONT_LAT; k++) mag_r[k] <= mag_r[k-1];

    tx3_r   <= mag_r[2].mpx * mag_r[2].mdx;
    ty3_r   <= mag_r[2].mpy * mag_r[2].mdy;
    lx3_r   <= mag_r[2].mdx * mag_r[2].mdx;
    ly3_r   <= mag_r[2].mdy * mag_r[2].mdy;
    negx3_r <= negx2_r;
    negy3_r <= negy2_r;

    len4_r <= lx3_r + ly3_r;
    dot4_r <= dot4_nxt;

    len5_r  <= len4_r;
    dneg5_r <= dot4_r[TW-1];
    dmag5_r <= dot4_r[TW-1] ? LW'(-dot4_r) : LW'(dot4_r);
    zero5_r <= len4_r == '0;

    len6_r <= len5_r;
    reg6_r <= reg6_nxt;
    nb6_r  <= (reg6_nxt == ppos_pkg::REG_PAST) ? e6[LW-1:0] : dmag5_r;

    hx7_r  <= nb6_r[LW-1:HW] * mag_r[6].mdx;
    lx7_r  <= nb6_r[HW-1:0]  * mag_r[6].mdx;
    hy7_r  <= nb6_r[LW-1:HW] * mag_r[6].mdy;
    ly7_r  <= nb6_r[HW-1:0]  * mag_r[6].mdy;
    len7_r <= len6_r;
    reg7_r <= reg6_r;

    numx8_r <= (((NW'(hx7_r) << HW) + NW'(lx7_r)) << 1) + NW'(len7_r);
    numy8_r <= (((NW'(hy7_r) << HW) + NW'(ly7_r)) << 1) + NW'(len7_r);
    den8_r  <= (reg7_r == ppos_pkg::REG_ZERO) ? EW'(2) : {len7_r, 1'b0};
    reg8_r  <= reg7_r;
  end

  // ---------------------------------------------------------------- divide
  logic          divx_vld, divy_vld;
  logic [QW-1:0] quot_x, quot_y;
  dly_t          dly_r [0:DL-1];

  ppos_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[ppos_pkg::FRONT_LAT]),
    .num       (numx8_r),
    .den       (den8_r),
    .out_valid (divx_vld),
    .quot      (quot_x)
  );

  ppos_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[ppos_pkg::FRONT_LAT]),
    .num       (numy8_r),
    .den       (den8_r),
    .out_valid (divy_vld),
    .quot      (quot_y)
  );

  // Side data travels alongside the dividers.
  always_ff @(posedge clk) begin
    dly_r[0].crd    <= crd_r[ppos_pkg::FRONT_LAT];
    dly_r[0].mg     <= mag_r[ppos_pkg::FRONT_LAT];
    dly_r[0].region <= reg8_r;
    for (int k = 1; k < DL; k++) dly_r[k] <= dly_r[k-1];
  end

  // ---------------------------------------------------------------- back
  dly_t                 dq;
  logic signed [FW-1:0] fx9_nxt, fy9_nxt;
  logic                 v9_r, v10_r, v11_r;
  logic signed [FW-1:0] fx9_r, fy9_r;
  logic [SW-1:0]        oux9_r, ouy9_r;
  logic                 osat9_r;
  crd_t                 crd9_r;
  mag_t                 mag9_r;
  logic [1:0]           reg9_r;
  logic [SW-1:0]        oux10_r, ouy10_r, sux10_r, suy10_r;
  logic                 osat10_r;
  logic signed [CO-1:0] fx10_r, fy10_r;
  logic [1:0]           reg10_r;
  logic [2*SW-1:0]      sqox11_r, sqoy11_r, sqsx11_r, sqsy11_r;
  logic                 osat11_r;
  bdl_t                 bdl_r [0:RL];

  assign dq = dly_r[DL-1];

  // Foot point: offset from the start inside, else the nearer end.
  always_comb begin : p_foot
    logic signed [FW-1:0] ox, oy;
    ox = $signed({1'b0, quot_x[DF-1:0]});
    oy = $signed({1'b0, quot_y[DF-1:0]});
    case (dq.region)
      ppos_pkg::REG_INSIDE: begin
        fx9_nxt = FW'(dq.crd.ax) + (dq.mg.dxn ? -ox : ox);
        fy9_nxt = FW'(dq.crd.ay) + (dq.mg.dyn ? -oy : oy);
      end
      ppos_pkg::REG_PAST: begin
        fx9_nxt = FW'(dq.crd.bx);
        fy9_nxt = FW'(dq.crd.by);
      end
      default: begin
        fx9_nxt = FW'(dq.crd.ax);
        fy9_nxt = FW'(dq.crd.ay);
      end
    endcase
  end

  // Back valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else begin
      v9_r  <= divx_vld && divy_vld;
      v10_r <= v9_r;
      v11_r <= v10_r;
    end
  end

  // Back datapath: foot, distance operands, squares.
  always_ff @(posedge clk) begin
    fx9_r  <= fx9_nxt;
    fy9_r  <= fy9_nxt;
    crd9_r <= dq.crd;
    mag9_r <= dq.mg;
    reg9_r <= dq.region;
    if (dq.region == ppos_pkg::REG_BEFORE || dq.region == ppos_pkg::REG_PAST) begin
      oux9_r  <= quot_x[SW-1:0];
      ouy9_r  <= quot_y[SW-1:0];
      osat9_r <= (quot_x > QW'(ppos_pkg::DIST_MAX)) || (quot_y > QW'(ppos_pkg::DIST_MAX));
    end else begin
      oux9_r  <= '0;
      ouy9_r  <= '0;
      osat9_r <= 1'b0;
    end

    oux10_r  <= oux9_r;
    ouy10_r  <= ouy9_r;
    osat10_r <= osat9_r;
    fx10_r   <= fx9_r[CO-1:0];
    fy10_r   <= fy9_r[CO-1:0];
    reg10_r  <= reg9_r;
    case (reg9_r)
      ppos_pkg::REG_INSIDE: begin
        sux10_r <= mag26_f(FW'(crd9_r.x) - fx9_r);
        suy10_r <= mag26_f(FW'(crd9_r.y) - fy9_r);
      end
      ppos_pkg::REG_PAST: begin
        sux10_r <= {1'b0, mag9_r.mqx};
        suy10_r <= {1'b0, mag9_r.mqy};
      end
      default: begin
        sux10_r <= {1'b0, mag9_r.mpx};
        suy10_r <= {1'b0, mag9_r.mpy};
      end
    endcase

    sqox11_r <= oux10_r * oux10_r;
    sqoy11_r <= ouy10_r * ouy10_r;
    sqsx11_r <= sux10_r * sux10_r;
    sqsy11_r <= suy10_r * suy10_r;
    osat11_r <= osat10_r;

    // The first entry lines up with the square root input; the last with its output.
    bdl_r[0].fx     <= fx10_r;
    bdl_r[0].fy     <= fy10_r;
    bdl_r[0].region <= reg10_r;
    for (int k = 1; k <= RL; k++) bdl_r[k] <= bdl_r[k-1];
  end

  // ---------------------------------------------------------------- roots
  logic sqo_vld, sqs_vld;

  ppos_sqrt u_sqrt_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v11_r),
    .val       (VW'(sqox11_r) + VW'(sqoy11_r)),
    .sat       (osat11_r),
    .out_valid (sqo_vld),
    .distance  (out_outside_distance)
  );

  ppos_sqrt u_sqrt_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v11_r),
    .val       (VW'(sqsx11_r) + VW'(sqsy11_r)),
    .sat       (1'b0),
    .out_valid (sqs_vld),
    .distance  (out_segment_distance)
  );

  assign out_strobe = sqo_vld && sqs_vld;
  assign out_foot_x = bdl_r[RL].fx;
  assign out_foot_y = bdl_r[RL].fy;
  assign out_region = bdl_r[RL].region;

endmodule

/* rtl/core/ppos_div.sv */
// ----------------------------------------------------------------------------
// ppos_div: pipelined rounded divider
// Restoring division, one quotient bit per stage. A quotient that does not fit
// in the quotient width comes out as all ones.
// ----------------------------------------------------------------------------
module ppos_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ppos_pkg::NUM_W-1:0]    num,
  input  logic [ppos_pkg::DEN_W-1:0]    den,
  output logic                          out_valid,
  output logic [ppos_pkg::QUOT_W-1:0]   quot
);

  localparam int QW = ppos_pkg::QUOT_W;
  localparam int DW = ppos_pkg::DEN_W;
  localparam int NW = ppos_pkg::NUM_W;

  logic          vld_r [0:QW];
  logic [DW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] lo_r  [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          sat_r [0:QW];

  logic [DW-1:0] rem_nxt [1:QW];
  logic [QW-1:0] q_nxt   [1:QW];

  // Each stage shifts in one numerator bit and tries one subtraction.
  always_comb begin : p_step
    logic [DW:0] t;
    t = '0;
    for (int k = 1; k <= QW; k++) begin
      t = {rem_r[k-1], lo_r[k-1][QW-1]};
      if (t >= {1'b0, den_r[k-1]}) begin
        rem_nxt[k] = DW'(t - {1'b0, den_r[k-1]});
        q_nxt[k]   = {q_r[k-1][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = DW'(t);
        q_nxt[k]   = {q_r[k-1][QW-2:0], 1'b0};
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= QW; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Stage registers. The first stage also detects quotient overflow.
  always_ff @(posedge clk) begin
    rem_r[0] <= DW'(num[NW-1:QW]);
    lo_r[0]  <= num[QW-1:0];
    den_r[0] <= den;
    q_r[0]   <= '0;
    sat_r[0] <= DW'(num[NW-1:QW]) >= den;
    for (int k = 1; k <= QW; k++) begin
      rem_r[k] <= rem_nxt[k];
      lo_r[k]  <= {lo_r[k-1][QW-2:0], 1'b0};
      den_r[k] <= den_r[k-1];
      q_r[k]   <= q_nxt[k];
      sat_r[k] <= sat_r[k-1];
    end
  end

  assign out_valid = vld_r[QW];
  assign quot      = sat_r[QW] ? '1 : q_r[QW];

endmodule

/* rtl/core/ppos_sqrt.sv */
// ----------------------------------------------------------------------------
// ppos_sqrt: pipelined rounded square root
// One root bit per stage, then a rounding stage that also saturates.
// ----------------------------------------------------------------------------
module ppos_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ppos_pkg::SQ_W-1:0]     val,
  input  logic                          sat,
  output logic                          out_valid,
  output logic [ppos_pkg::DIST_W-1:0]   distance
);

  localparam int RW = ppos_pkg::ROOT_W;
  localparam int CW = ppos_pkg::SQ_W + 2;

  logic          vld_r  [0:RW];
  logic [CW-1:0] rem_r  [0:RW];
  logic [RW-1:0] root_r [0:RW];
  logic          sat_r  [0:RW];

  logic [CW-1:0] rem_nxt  [1:RW];
  logic [RW-1:0] root_nxt [1:RW];

  logic                          out_vld_r;
  logic [ppos_pkg::DIST_W-1:0]   dist_r;
  logic [ppos_pkg::DIST_W-1:0]   dist_nxt;

  // Stage k decides root bit RW-k against the running remainder.
  always_comb begin : p_step
    logic [CW-1:0] cand;
    cand = '0;
    for (int k = 1; k <= RW; k++) begin
      cand = (CW'(root_r[k-1]) << (RW - k + 1)) | (CW'(1) << (2 * (RW - k)));
      if (rem_r[k-1] >= cand) begin
        rem_nxt[k]  = rem_r[k-1] - cand;
        root_nxt[k] = root_r[k-1] | (RW'(1) << (RW - k));
      end else begin
        rem_nxt[k]  = rem_r[k-1];
        root_nxt[k] = root_r[k-1];
      end
    end
  end

  // Round to nearest: bump when the remainder exceeds the root.
  always_comb begin : p_round
    logic [RW:0] rnd;
    rnd = (RW+1)'(root_r[RW]) + ((rem_r[RW] > CW'(root_r[RW])) ? (RW+1)'(1) : '0);
    if (sat_r[RW] || rnd > (RW+1)'(ppos_pkg::DIST_MAX)) begin
      dist_nxt = ppos_pkg::DIST_MAX;
    end else begin
      dist_nxt = rnd[ppos_pkg::DIST_W-1:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= RW; k++) vld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= RW; k++) vld_r[k] <= vld_r[k-1];
      out_vld_r <= vld_r[RW];
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    rem_r[0]  <= CW'(val);
    root_r[0] <= '0;
    sat_r[0]  <= sat;
    for (int k = 1; k <= RW; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      sat_r[k]  <= sat_r[k-1];
    end
    dist_r <= dist_nxt;
  end

  assign out_valid = out_vld_r;
  assign distance  = dist_r;

endmodule

/* rtl/core/ppos_chk.sv */
// ----------------------------------------------------------------------------
// ppos_chk: port-level checks for the projection block
// Latency, reset, busy and region consistency seen on the top level's ports.
// ----------------------------------------------------------------------------
module ppos_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [ppos_pkg::COORD_W-1:0]  in_point_x,
  input logic signed [ppos_pkg::COORD_W-1:0]  in_point_y,
  input logic signed [ppos_pkg::COORD_W-1:0]  in_start_x,
  input logic signed [ppos_pkg::COORD_W-1:0]  in_start_y,
  input logic signed [ppos_pkg::COORD_W-1:0]  in_stop_x,
  input logic signed [ppos_pkg::COORD_W-1:0]  in_stop_y,
  input logic                                 out_strobe,
  input logic signed [ppos_pkg::COORD_W-1:0]  out_foot_x,
  input logic signed [ppos_pkg::COORD_W-1:0]  out_foot_y,
  input logic [ppos_pkg::DIST_W-1:0]          out_outside_distance,
  input logic [ppos_pkg::DIST_W-1:0]          out_segment_distance,
  input logic [1:0]                           out_region
);

  // Every result beat comes from a beat taken a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, ppos_pkg::TOTAL_LAT))
    else $error("result beat without a matching input beat");

  // Reset flushes the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result beat right after reset");

  // Inside or degenerate segments have no distance beyond an end.
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_region == ppos_pkg::REG_INSIDE || out_region == ppos_pkg::REG_ZERO)
    |-> out_outside_distance == '0)
    else $error("outside distance set for an inside foot");

  // The block never refuses a beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind project_point_onto_segment ppos_chk u_ppos_chk (.*);

/* verif/project_point_onto_segment_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// project_point_onto_segment_checker: result predictor and scoreboard
// Watches the input and result channels of the projection block, works out
// each expected result from the accepted beat and compares field by field.
// ----------------------------------------------------------------------------
module project_point_onto_segment_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [ppos_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [ppos_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [ppos_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [ppos_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [ppos_pkg::COORD_W-1:0] in_stop_x,
  input  logic signed [ppos_pkg::COORD_W-1:0] in_stop_y,
  input  logic                                out_strobe,
  input  logic signed [ppos_pkg::COORD_W-1:0] out_foot_x,
  input  logic signed [ppos_pkg::COORD_W-1:0] out_foot_y,
  input  logic [ppos_pkg::DIST_W-1:0]         out_outside_distance,
  input  logic [ppos_pkg::DIST_W-1:0]         out_segment_distance,
  input  logic [1:0]                          out_region,
  output int                                  error_count,
  output int                                  pending_count,
  output int                                  region_hits [4]
);
  import ppos_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] foot_x;
    logic [COORD_W-1:0] foot_y;
    logic [DIST_W-1:0]  outside;
    logic [DIST_W-1:0]  seg;
    logic [1:0]         region;
  } projection_t;

  localparam longint unsigned DMAX = (64'd1 << DIST_W) - 1;
  localparam logic [127:0]    QCAP = 128'd1 << 62;

  projection_t expected_q[$];

  // Rounded quotient n / d with halves up, capped at 1 << 62.
  function automatic logic [127:0] rounded_quotient(logic [127:0] n, logic [127:0] d);
    logic [127:0] q;
    q = ((n << 1) + d) / (d << 1);
    return (q > QCAP) ? QCAP : q;
  endfunction

  // Square root rounded to nearest.
  function automatic longint unsigned rounded_root(longint unsigned v);
    longint unsigned x, r, b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r * r + r) r = r + 1;
    return r;
  endfunction

  // Euclidean length of an integer vector, saturating.
  function automatic logic [DIST_W-1:0] length_of(logic [127:0] ux, logic [127:0] uy);
    longint unsigned r;
    if (ux > DMAX || uy > DMAX) return DIST_MAX;
    r = rounded_root(ux[63:0] * ux[63:0] + uy[63:0] * uy[63:0]);
    return (r > DMAX) ? DIST_MAX : r[DIST_W-1:0];
  endfunction

  function automatic logic [127:0] magnitude(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // Clamped projection of the point onto the segment.
  function automatic projection_t project(longint x, longint y, longint ax, longint ay,
                                          longint bx, longint by);
    projection_t res;
    longint dx, dy, px, py, fx, fy, ox, oy;
    logic [127:0] mdx, mdy, mpx, mpy, len2, pos, neg, dot, ex;
    logic dot_neg;
    dx = bx - ax;
    dy = by - ay;
    px = x - ax;
    py = y - ay;
    mdx = magnitude(dx);
    mdy = magnitude(dy);
    mpx = magnitude(px);
    mpy = magnitude(py);
    len2 = mdx * mdx + mdy * mdy;
    pos = 0;
    neg = 0;
    if ((px < 0) != (dx < 0)) neg = neg + mpx * mdx; else pos = pos + mpx * mdx;
    if ((py < 0) != (dy < 0)) neg = neg + mpy * mdy; else pos = pos + mpy * mdy;
    dot_neg = pos < neg;
    dot = dot_neg ? neg - pos : pos - neg;
    res.outside = '0;
    if (len2 == 0) begin
      res.region = REG_ZERO;
      fx = ax;
      fy = ay;
      res.seg = length_of(mpx, mpy);
    end else if (dot_neg) begin
      res.region = REG_BEFORE;
      fx = ax;
      fy = ay;
      res.outside = length_of(rounded_quotient(dot * mdx, len2),
                              rounded_quotient(dot * mdy, len2));
      res.seg = length_of(mpx, mpy);
    end else if (dot > len2) begin
      ex = dot - len2;
      res.region = REG_PAST;
      fx = bx;
      fy = by;
      res.outside = length_of(rounded_quotient(ex * mdx, len2),
                              rounded_quotient(ex * mdy, len2));
      res.seg = length_of(magnitude(x - bx), magnitude(y - by));
    end else begin
      ox = longint'(rounded_quotient(dot * mdx, len2));
      oy = longint'(rounded_quotient(dot * mdy, len2));
      res.region = REG_INSIDE;
      fx = ax + ((dx < 0) ? -ox : ox);
      fy = ay + ((dy < 0) ? -oy : oy);
      res.seg = length_of(magnitude(x - fx), magnitude(y - fy));
    end
    res.foot_x = fx[COORD_W-1:0];
    res.foot_y = fy[COORD_W-1:0];
    return res;
  endfunction

  initial begin
    error_count = 0;
    for (int i = 0; i < 4; i++) region_hits[i] = 0;
  end

  assign pending_count = expected_q.size();

  // Predict on every accepted beat; compare on every result strobe.
  always @(posedge clk) begin
    projection_t want;
    if (rst_n && start && !busy) begin
      want = project(in_point_x, in_point_y, in_start_x, in_start_y,
                     in_stop_x, in_stop_y);
      expected_q.push_back(want);
      region_hits[want.region]++;
    end
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t: result with no beat outstanding: foot %0d,%0d region %0d", $time,
                 out_foot_x, out_foot_y, out_region);
      end else begin
        want = expected_q.pop_front();
        if (out_foot_x !== want.foot_x) begin
          error_count++;
          $display("%0t: foot_x expected %0d, actual %0d", $time,
                   $signed(want.foot_x), out_foot_x);
        end
        if (out_foot_y !== want.foot_y) begin
          error_count++;
          $display("%0t: foot_y expected %0d, actual %0d", $time,
                   $signed(want.foot_y), out_foot_y);
        end
        if (out_outside_distance !== want.outside) begin
          error_count++;
          $display("%0t: outside_distance expected %0d, actual %0d", $time,
                   want.outside, out_outside_distance);
        end
        if (out_segment_distance !== want.seg) begin
          error_count++;
          $display("%0t: segment_distance expected %0d, actual %0d", $time,
                   want.seg, out_segment_distance);
        end
        if (out_region !== want.region) begin
          error_count++;
          $display("%0t: region expected %0d, actual %0d", $time,
                   want.region, out_region);
        end
      end
    end
  end

endmodule

/* verif/project_point_onto_segment_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// project_point_onto_segment_test: stimulus and verdict for the projection
// Sends directed corner cases and random segments and points with random
// gaps; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module project_point_onto_segment_test;
  import ppos_pkg::*;

  localparam int  RANDOM_BEATS = 1630;
  localparam int  STALL_LIMIT  = 4 * TOTAL_LAT + 200;
  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [COORD_W-1:0] in_point_x, in_point_y, in_start_x, in_start_y;
  logic signed [COORD_W-1:0] in_stop_x, in_stop_y;
  logic out_strobe;
  logic signed [COORD_W-1:0] out_foot_x, out_foot_y;
  logic [DIST_W-1:0] out_outside_distance, out_segment_distance;
  logic [1:0] out_region;
  int error_count, pending_count;
  int region_hits [4];
  int beats_sent;
  int idle_cycles;

  project_point_onto_segment i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_stop_x           (in_stop_x),
    .in_stop_y           (in_stop_y),
    .out_strobe          (out_strobe),
    .out_foot_x          (out_foot_x),
    .out_foot_y          (out_foot_y),
    .out_outside_distance(out_outside_distance),
    .out_segment_distance(out_segment_distance),
    .out_region          (out_region)
  );

  project_point_onto_segment_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_stop_x           (in_stop_x),
    .in_stop_y           (in_stop_y),
    .out_strobe          (out_strobe),
    .out_foot_x          (out_foot_x),
    .out_foot_y          (out_foot_y),
    .out_outside_distance(out_outside_distance),
    .out_segment_distance(out_segment_distance),
    .out_region          (out_region),
    .error_count         (error_count),
    .pending_count       (pending_count),
    .region_hits         (region_hits)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles in which no beat and no result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_count);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one beat and hold it until it is taken.
  task automatic send_beat(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                           logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
                           logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
    start      <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_start_x <= ax;
    in_start_y <= ay;
    in_stop_x  <= bx;
    in_stop_y  <= by;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinate of a chosen spread: full range, small, near an extreme, or medium.
  function automatic logic signed [COORD_W-1:0] pick_coord(int kind);
    case (kind)
      0:       return COORD_W'($urandom);
      1:       return COORD_W'($signed($urandom_range(0, 4095)) - 2048);
      2:       return $urandom_range(0, 1) ? CMAX - COORD_W'($urandom_range(0, 3))
                                           : CMIN + COORD_W'($urandom_range(0, 3));
      default: return COORD_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  initial begin
    logic signed [COORD_W-1:0] ax, ay, bx, by, px, py;
    int kind;
    int mode;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_point_x  = '0;
    in_point_y  = '0;
    in_start_x  = '0;
    in_start_y  = '0;
    in_stop_x   = '0;
    in_stop_y   = '0;
    beats_sent  = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: each region, the boundaries and the extremes.
    send_beat(0, 0, 0, 0, 0, 0);
    send_beat(CMAX, CMAX, 0, 0, 0, 0);
    send_beat(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);
    send_beat(128, 512, 0, 0, 1024, 0);
    send_beat(-300, 40, 0, 0, 1024, 0);
    send_beat(2000, -40, 0, 0, 1024, 0);
    send_beat(0, 0, 0, 0, 1024, 1024);
    send_beat(1024, 1024, 0, 0, 1024, 1024);
    send_beat(-7, 300, 100, 100, -500, 700);
    send_beat(CMAX, 0, 0, 0, 1, 0);
    send_beat(CMIN, CMAX, 0, 0, 1, 0);
    send_beat(CMAX, CMAX, 0, 0, 1, 1);
    send_beat(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN);
    send_beat(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
    send_beat(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
    send_beat(0, 0, CMIN, CMIN, CMAX, CMAX);
    send_beat(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX);
    send_beat(1, 0, 0, 0, 2, 0);
    send_beat(3, 1, 0, 0, 2, 2);
    send_beat(-1, -1, 5, -3, 5, -3);
    idle_cycle();

    // Let the pipeline drain before the random part starts.
    while (pending_count != 0) @(posedge clk);

    // Random beats; a stretch in the middle runs without gaps.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if ((n < 600 || n > 900) && $urandom_range(0, 99) < 12) idle_cycle();
      if (n == 1200) begin
        idle_cycle();
        while (pending_count != 0) @(posedge clk);
      end
      mode = $urandom_range(0, 99);
      kind = $urandom_range(0, 3);
      ax = pick_coord(kind);
      ay = pick_coord(kind);
      if (mode < 10) begin
        // Zero-length segment.
        bx = ax;
        by = ay;
      end else if (mode < 20) begin
        // Very short segment, so the parameter can be huge.
        bx = ax + COORD_W'($signed($urandom_range(0, 6)) - 3);
        by = ay + COORD_W'($signed($urandom_range(0, 6)) - 3);
      end else begin
        bx = pick_coord(kind);
        by = pick_coord(kind);
      end
      if (mode >= 20 && mode < 28) begin
        // Point exactly on one end.
        px = $urandom_range(0, 1) ? ax : bx;
        py = (px == ax) ? ay : by;
      end else begin
        px = pick_coord($urandom_range(0, 3));
        py = pick_coord($urandom_range(0, 3));
      end
      send_beat(px, py, ax, ay, bx, by);
    end
    idle_cycle();

    // Drain, then allow the full latency for any stray strobe.
    while (pending_count != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);

    $display("Sent %0d beats: %0d inside, %0d before start, %0d past stop, %0d zero length.",
             beats_sent, region_hits[REG_INSIDE], region_hits[REG_BEFORE],
             region_hits[REG_PAST], region_hits[REG_ZERO]);
    $display("Mismatches found: %0d.", error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
